FILE: hw/rtl/spi_master_register_block_defines.svh
// assertion macros for the spi master register block
`ifndef SPI_MASTER_REGISTER_BLOCK_DEFINES_SVH
`define SPI_MASTER_REGISTER_BLOCK_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SMRB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smrb check failed");

// next-cycle implication, disabled during reset
`define SMRB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smrb check failed");

`endif

FILE: hw/rtl/smrb_pkg.sv
// types and constants shared by the spi master register block
package smrb_pkg;

  typedef struct packed {
    logic        req_type;
    logic [11:0] addr;
    logic [31:0] write_data;
    logic [7:0]  miso_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        xfer_valid;
    logic [7:0]  mosi_byte;
    logic        irq_line;
    logic [3:0]  cs_n;
  } rsp_t;

  // request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // register offsets
  localparam logic [11:0] ADDR_CR1    = 12'h000;
  localparam logic [11:0] ADDR_CR2    = 12'h004;
  localparam logic [11:0] ADDR_SR     = 12'h008;
  localparam logic [11:0] ADDR_DR     = 12'h00C;
  localparam logic [11:0] ADDR_CSCTRL = 12'h010;

  // writable bit masks
  localparam logic [7:0] CR1_MASK    = 8'h44;
  localparam logic [7:0] CR2_MASK    = 8'hF0;
  localparam logic [7:0] CSCTRL_MASK = 8'hFF;

  // bit positions
  localparam int unsigned CR1_SPE    = 6;
  localparam int unsigned CR1_MSTR   = 2;
  localparam int unsigned CR2_TXEIE  = 7;
  localparam int unsigned CR2_RXNEIE = 6;
  localparam int unsigned CR2_ERRIE  = 5;
  localparam int unsigned SR_OVR     = 3;
  localparam int unsigned SR_UDR     = 2;
  localparam int unsigned SR_TXE     = 1;
  localparam int unsigned SR_RXNE    = 0;

  localparam int unsigned MAX_CS = 4;

endpackage

FILE: hw/rtl/smrb_if.sv
// valid/ready channel interfaces for requests and responses
interface smrb_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] addr;
  logic [31:0] write_data;
  logic [7:0]  miso_byte;

  modport source (output valid, req_type, addr, write_data, miso_byte, input ready);
  modport sink   (input valid, req_type, addr, write_data, miso_byte, output ready);
endinterface

interface smrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_error;
  logic        xfer_valid;
  logic [7:0]  mosi_byte;
  logic        irq_line;
  logic [3:0]  cs_n;

  modport source (output valid, read_data, access_error, xfer_valid, mosi_byte,
                  irq_line, cs_n, input ready);
  modport sink   (input valid, read_data, access_error, xfer_valid, mosi_byte,
                  irq_line, cs_n, output ready);
endinterface

FILE: hw/rtl/spi_master_register_block.sv
// top level of the spi master register block
// register-mapped spi master: each request transfer is one 32-bit bus read or write to
// CR1 (0x00), CR2 (0x04), SR (0x08), DR (0x0C) or CSCTRL (0x10), and gives exactly one
// response transfer with read data, access error, the bus byte if one was shifted, the
// interrupt level and the active-low chip selects. a request is registered on entry and
// its response is registered on exit, and one request is taken every cycle while the
// response side keeps up; the register update itself is one pass of decode logic between
// those two registers. a DR write when enabled as master, with no byte held, sends its
// byte in the same access and takes miso_byte as the received byte if the receive
// register is empty. there is no clearing pass after reset.
`include "spi_master_register_block_defines.svh"

module spi_master_register_block #(
  parameter int unsigned NUM_CHIP_SELECTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smrb_req_if.sink   req_i,
  smrb_rsp_if.source rsp_o
);
  import smrb_pkg::*;

  req_t req_in;
  req_t req_q;
  rsp_t rsp_next;
  rsp_t rsp_q;
  logic in_valid;
  logic out_free;
  logic take;      // item moves from input register into result register

  // pack the request channel
  assign req_in.req_type   = req_i.req_type;
  assign req_in.addr       = req_i.addr;
  assign req_in.write_data = req_i.write_data;
  assign req_in.miso_byte  = req_i.miso_byte;

  assign take = in_valid && out_free;

  smrb_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .req_i   (req_in),
    .take_i  (take),
    .valid_o (in_valid),
    .req_o   (req_q)
  );

  // state changes only when the item is handed on
  smrb_core #(
    .NumChipSelects (NUM_CHIP_SELECTS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (take),
    .req_i  (req_q),
    .rsp_o  (rsp_next)
  );

  smrb_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .rsp_i   (rsp_next),
    .free_o  (out_free),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .rsp_o   (rsp_q)
  );

  // unpack the response channel
  assign rsp_o.read_data    = rsp_q.read_data;
  assign rsp_o.access_error = rsp_q.access_error;
  assign rsp_o.xfer_valid   = rsp_q.xfer_valid;
  assign rsp_o.mosi_byte    = rsp_q.mosi_byte;
  assign rsp_o.irq_line     = rsp_q.irq_line;
  assign rsp_o.cs_n         = rsp_q.cs_n;

  // a handed-on item always shows up as a response next cycle
  `SMRB_ASSERT_NXT(a_take_gives_rsp, clk_i, rst_ni, take, rsp_o.valid)
  // a waiting request is not lost while the response side stalls
  `SMRB_ASSERT_NXT(a_in_holds, clk_i, rst_ni, in_valid && !take, in_valid)
  // a bus transfer only comes from a good write, which returns no data
  `SMRB_ASSERT_IMP(a_xfer_clean, clk_i, rst_ni, rsp_o.valid && rsp_o.xfer_valid,
    !rsp_o.access_error && (rsp_o.read_data == 32'd0))
endmodule

FILE: hw/rtl/smrb_in_stage.sv
// request input register
module smrb_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  smrb_pkg::req_t req_i,
  input  logic          take_i,
  output logic          valid_o,
  output smrb_pkg::req_t req_o
);
  import smrb_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;
  logic load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;
endmodule

FILE: hw/rtl/smrb_core.sv
// register file, status flags and access decode
module smrb_core #(
  parameter int unsigned NumChipSelects = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  smrb_pkg::req_t req_i,
  output smrb_pkg::rsp_t rsp_o
);
  import smrb_pkg::*;

  logic [7:0] cr1_q, cr1_d;
  logic [7:0] cr2_q, cr2_d;
  logic [7:0] csc_q, csc_d;
  logic       ovr_q, ovr_d;
  logic       udr_q, udr_d;
  logic       tx_held_q, tx_held_d;   // tx empty flag is its inverse
  logic       rx_held_q, rx_held_d;   // rx not empty flag is the same bit
  logic [7:0] rx_byte_q, rx_byte_d;
  logic       bad_addr;
  logic       master_en;
  logic       is_write;
  logic [3:0] status;
  rsp_t       rsp;

  assign bad_addr  = (req_i.addr > ADDR_CSCTRL) || (req_i.addr[1:0] != 2'b00);
  assign master_en = cr1_q[CR1_SPE] && cr1_q[CR1_MSTR];
  assign is_write  = (req_i.req_type == REQ_WRITE);

  always_comb begin
    status          = '0;
    status[SR_OVR]  = ovr_q;
    status[SR_UDR]  = udr_q;
    status[SR_TXE]  = !tx_held_q;
    status[SR_RXNE] = rx_held_q;
  end

  always_comb begin
    cr1_d     = cr1_q;
    cr2_d     = cr2_q;
    csc_d     = csc_q;
    ovr_d     = ovr_q;
    udr_d     = udr_q;
    tx_held_d = tx_held_q;
    rx_held_d = rx_held_q;
    rx_byte_d = rx_byte_q;
    rsp       = '0;

    priority if (bad_addr) begin
      rsp.access_error = 1'b1;
    end else if (!is_write) begin
      unique case (req_i.addr)
        ADDR_CR1:    rsp.read_data = {24'd0, cr1_q};
        ADDR_CR2:    rsp.read_data = {24'd0, cr2_q};
        ADDR_SR:     rsp.read_data = {28'd0, status};
        ADDR_DR: begin
          if (rx_held_q) begin
            rsp.read_data = {24'd0, rx_byte_q};
            rx_held_d     = 1'b0;
          end else begin
            udr_d = 1'b1;
          end
        end
        default:     rsp.read_data = {24'd0, csc_q};
      endcase
    end else begin
      unique case (req_i.addr)
        ADDR_CR1: cr1_d = req_i.write_data[7:0] & CR1_MASK;
        ADDR_CR2: cr2_d = req_i.write_data[7:0] & CR2_MASK;
        ADDR_SR: begin
          if (req_i.write_data[SR_OVR]) ovr_d = 1'b0;
          if (req_i.write_data[SR_UDR]) udr_d = 1'b0;
        end
        ADDR_DR: begin
          if (tx_held_q) begin
            ovr_d = 1'b1;
          end else if (master_en) begin
            // byte goes straight out, slave byte comes back
            rsp.xfer_valid = 1'b1;
            rsp.mosi_byte  = req_i.write_data[7:0];
            if (rx_held_q) begin
              ovr_d = 1'b1;
            end else begin
              rx_held_d = 1'b1;
              rx_byte_d = req_i.miso_byte;
            end
          end else begin
            tx_held_d = 1'b1;
          end
        end
        default:  csc_d = req_i.write_data[7:0] & CSCTRL_MASK;
      endcase
    end

    // interrupt and chip selects reflect the state after this access
    rsp.irq_line = (cr2_d[CR2_TXEIE] && !tx_held_d) ||
                   (cr2_d[CR2_RXNEIE] && rx_held_d) ||
                   (cr2_d[CR2_ERRIE] && (ovr_d || udr_d));
    for (int i = 0; i < MAX_CS; i++) begin
      rsp.cs_n[i] = !((i < NumChipSelects) && csc_d[i] && csc_d[i + MAX_CS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr1_q     <= '0;
      cr2_q     <= '0;
      csc_q     <= '0;
      ovr_q     <= 1'b0;
      udr_q     <= 1'b0;
      tx_held_q <= 1'b0;
      rx_held_q <= 1'b0;
    end else if (fire_i) begin
      cr1_q     <= cr1_d;
      cr2_q     <= cr2_d;
      csc_q     <= csc_d;
      ovr_q     <= ovr_d;
      udr_q     <= udr_d;
      tx_held_q <= tx_held_d;
      rx_held_q <= rx_held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      rx_byte_q <= rx_byte_d;
    end
  end

  assign rsp_o = rsp;
endmodule

FILE: hw/rtl/smrb_out_stage.sv
// response output register
module smrb_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  smrb_pkg::rsp_t rsp_i,
  output logic           free_o,
  output logic           valid_o,
  input  logic           ready_i,
  output smrb_pkg::rsp_t rsp_o
);
  import smrb_pkg::*;

  logic valid_q, valid_d;
  rsp_t rsp_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;
endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the spi master register block
module tb_top;
  import smrb_pkg::*;

  localparam int unsigned NUM_CS = 4;
  // cycles with no transfer on either channel before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // cycles let pass after the last response, to watch for stray responses
  localparam int unsigned TAIL_CYCLES = 8;

  logic clk;
  logic rst_n;

  smrb_req_if req_if ();
  smrb_rsp_if rsp_if ();

  spi_master_register_block #(
    .NUM_CHIP_SELECTS(NUM_CS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // register image kept by the testbench, updated on every accepted request
  logic [7:0] cr1_q, cr2_q, csctrl_q;
  logic       txe_q, rxne_q, ovr_q, udr_q;
  logic       tx_hold_vld, rx_hold_vld;
  logic [7:0] tx_hold_byte, rx_hold_byte;

  rsp_t        expected_rsp_q[$];
  req_t        taken_req;
  rsp_t        want_rsp;
  int unsigned fails;
  int unsigned quiet_cycles;

  // traffic shaping: idle_on is shared by the sender and the receiver, the rest is for the receiver
  bit          idle_on;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // works out the response of one access and moves the register image on
  function automatic rsp_t predict_access(req_t r);
    rsp_t p;
    int   i;
    p = '0;
    if (r.addr > ADDR_CSCTRL || r.addr[1:0] != 2'b00) begin
      // bad or misaligned offset: read 0, write dropped, nothing changes
      p.access_error = 1'b1;
    end else if (r.req_type == REQ_READ) begin
      case (r.addr)
        ADDR_CR1: p.read_data = {24'h0, cr1_q};
        ADDR_CR2: p.read_data = {24'h0, cr2_q};
        ADDR_SR:  p.read_data = {28'h0, ovr_q, udr_q, txe_q, rxne_q};
        ADDR_DR: begin
          if (rx_hold_vld) begin
            p.read_data = {24'h0, rx_hold_byte};
            rx_hold_vld = 1'b0;
            rxne_q      = 1'b0;
          end else begin
            // popping an empty receive register flags underrun
            udr_q = 1'b1;
          end
        end
        default: p.read_data = {24'h0, csctrl_q};
      endcase
    end else begin
      case (r.addr)
        ADDR_CR1: cr1_q = r.write_data[7:0] & CR1_MASK;
        ADDR_CR2: cr2_q = r.write_data[7:0] & CR2_MASK;
        ADDR_SR: begin
          // write-one-to-clear on the two error flags
          if (r.write_data[SR_OVR]) ovr_q = 1'b0;
          if (r.write_data[SR_UDR]) udr_q = 1'b0;
        end
        ADDR_DR: begin
          if (tx_hold_vld) begin
            // a byte is still held, the new one is lost
            ovr_q = 1'b1;
          end else begin
            tx_hold_byte = r.write_data[7:0];
            tx_hold_vld  = 1'b1;
            txe_q        = 1'b0;
            if (cr1_q[CR1_SPE] && cr1_q[CR1_MSTR]) begin
              p.xfer_valid = 1'b1;
              p.mosi_byte  = tx_hold_byte;
              tx_hold_vld  = 1'b0;
              txe_q        = 1'b1;
              if (!rx_hold_vld) begin
                rx_hold_byte = r.miso_byte;
                rx_hold_vld  = 1'b1;
                rxne_q       = 1'b1;
              end else begin
                // receive register full, incoming byte dropped
                ovr_q = 1'b1;
              end
            end
          end
        end
        default: csctrl_q = r.write_data[7:0] & CSCTRL_MASK;
      endcase
    end
    p.irq_line = (cr2_q[CR2_TXEIE] & txe_q) | (cr2_q[CR2_RXNEIE] & rxne_q) |
                 (cr2_q[CR2_ERRIE] & (ovr_q | udr_q));
    p.cs_n = 4'hF;
    for (i = 0; i < MAX_CS && i < NUM_CS; i++) begin
      if (csctrl_q[i] && csctrl_q[i + 4]) p.cs_n[i] = 1'b0;
    end
    return p;
  endfunction

  // prediction on each request transfer, comparison on each response transfer;
  // outputs are sampled at the rising edge, before the block's own updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        taken_req.req_type   = req_if.req_type;
        taken_req.addr       = req_if.addr;
        taken_req.write_data = req_if.write_data;
        taken_req.miso_byte  = req_if.miso_byte;
        expected_rsp_q.push_back(predict_access(taken_req));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response transfer with no request outstanding");
          fails++;
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (rsp_if.read_data !== want_rsp.read_data) begin
            $error("read_data: expected %h, actual %h", want_rsp.read_data, rsp_if.read_data);
            fails++;
          end
          if (rsp_if.access_error !== want_rsp.access_error) begin
            $error("access_error: expected %b, actual %b", want_rsp.access_error,
                   rsp_if.access_error);
            fails++;
          end
          if (rsp_if.xfer_valid !== want_rsp.xfer_valid) begin
            $error("xfer_valid: expected %b, actual %b", want_rsp.xfer_valid,
                   rsp_if.xfer_valid);
            fails++;
          end
          if (rsp_if.mosi_byte !== want_rsp.mosi_byte) begin
            $error("mosi_byte: expected %h, actual %h", want_rsp.mosi_byte, rsp_if.mosi_byte);
            fails++;
          end
          if (rsp_if.irq_line !== want_rsp.irq_line) begin
            $error("irq_line: expected %b, actual %b", want_rsp.irq_line, rsp_if.irq_line);
            fails++;
          end
          if (rsp_if.cs_n !== want_rsp.cs_n) begin
            $error("cs_n: expected %h, actual %h", want_rsp.cs_n, rsp_if.cs_n);
            fails++;
          end
        end
      end
    end
  end

  // watchdog: a run that stops moving is a failure
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // response side: random stall bursts, plus a long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        // start a stall burst of random length, this one included
        stall_left   = $urandom_range(0, 6);
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // offers one access from a falling edge and returns at the falling edge after
  // its transfer; valid stays high so back-to-back accesses need no gap
  task automatic send_access(input logic kind, input logic [11:0] addr,
                             input logic [31:0] wdata, input logic [7:0] miso);
    bit taken;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_if.req_type   = kind;
    req_if.addr       = addr;
    req_if.write_data = wdata;
    req_if.miso_byte  = miso;
    req_if.valid      = 1'b1;
    do begin
      @(posedge clk);
      taken = req_if.ready;
      @(negedge clk);
    end while (!taken);
  endtask

  // sender goes quiet until every outstanding response has come back
  task automatic wait_drain();
    req_if.valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
  endtask

  // weighted mix: mostly data register traffic, some control and status,
  // a little noise on any offset; keep_master stops cr1 writes from leaving
  // master mode, which would park a byte in the transmit register for good
  task automatic send_random_access(input bit keep_master);
    int unsigned pick;
    logic        kind;
    logic [11:0] addr;
    logic [31:0] wdata;
    logic [7:0]  miso;
    pick  = $urandom_range(0, 99);
    wdata = $urandom;
    miso  = 8'($urandom_range(0, 255));
    kind  = REQ_READ;
    if (pick < 30) begin
      kind = REQ_WRITE;
      addr = ADDR_DR;
    end else if (pick < 55) begin
      addr = ADDR_DR;
    end else if (pick < 63) begin
      addr = ADDR_SR;
    end else if (pick < 71) begin
      kind = REQ_WRITE;
      addr = ADDR_SR;
    end else if (pick < 77) begin
      kind = REQ_WRITE;
      addr = ADDR_CR2;
    end else if (pick < 83) begin
      kind = REQ_WRITE;
      addr = ADDR_CSCTRL;
    end else if (pick < 87) begin
      kind = REQ_WRITE;
      addr = ADDR_CR1;
    end else if (pick < 93) begin
      addr = $urandom_range(0, 1) ? ADDR_CR1 : ($urandom_range(0, 1) ? ADDR_CR2 : ADDR_CSCTRL);
    end else begin
      kind = 1'($urandom_range(0, 1));
      addr = 12'($urandom_range(0, 4095));
    end
    if (keep_master && kind == REQ_WRITE && addr == ADDR_CR1) begin
      wdata[CR1_SPE]  = 1'b1;
      wdata[CR1_MSTR] = 1'b1;
    end
    send_access(kind, addr, wdata, miso);
  endtask

  // every register straight out of reset, then an empty pop and its flag
  task automatic test_reset_values();
    send_access(REQ_READ, ADDR_CR1, 32'h0, 8'h00);
    send_access(REQ_READ, ADDR_CR2, 32'hFFFF_FFFF, 8'hFF);
    send_access(REQ_READ, ADDR_SR, 32'h0, 8'h00);
    send_access(REQ_READ, ADDR_DR, 32'h0, 8'h00);
    send_access(REQ_READ, ADDR_SR, 32'h0, 8'h00);
    send_access(REQ_READ, ADDR_CSCTRL, 32'h0, 8'h00);
  endtask

  // misaligned offsets, the first offset past the window, the top of the range and one in between
  task automatic test_bad_addresses();
    send_access(REQ_READ, 12'h001, 32'h0, 8'h00);
    send_access(REQ_WRITE, 12'h002, 32'hFFFF_FFFF, 8'hFF);
    send_access(REQ_READ, 12'h003, 32'h0, 8'h00);
    send_access(REQ_WRITE, 12'h014, 32'hFFFF_FFFF, 8'hFF);
    send_access(REQ_READ, 12'hFFF, 32'h0, 8'h00);
    send_access(REQ_WRITE, 12'h80C, 32'hFFFF_FFFF, 8'hFF);
  endtask

  // writable masks, interrupt enables and chip-select decoding
  task automatic test_control_regs();
    send_access(REQ_WRITE, ADDR_CR1, 32'hFFFF_FFFF, 8'h00);
    send_access(REQ_READ, ADDR_CR1, 32'h0, 8'h00);
    send_access(REQ_WRITE, ADDR_CR2, 32'hFFFF_FFFF, 8'h00);
    send_access(REQ_WRITE, ADDR_SR, 32'h0000_000C, 8'h00);
    send_access(REQ_WRITE, ADDR_CSCTRL, 32'hFFFF_FFFF, 8'h00);
    // enables and activity on different lines: nothing selected
    send_access(REQ_WRITE, ADDR_CSCTRL, 32'h0000_005A, 8'h00);
    send_access(REQ_WRITE, ADDR_CSCTRL, 32'h0000_0033, 8'h00);
    send_access(REQ_READ, ADDR_CSCTRL, 32'h0, 8'h00);
  endtask

  // shifted byte, a second shift into a full receive register, pops and clearing
  task automatic test_transfer();
    send_access(REQ_WRITE, ADDR_DR, 32'h0000_00A5, 8'h3C);
    send_access(REQ_WRITE, ADDR_DR, 32'hFFFF_FF5A, 8'hC3);
    send_access(REQ_READ, ADDR_DR, 32'h0, 8'h00);
    send_access(REQ_READ, ADDR_DR, 32'h0, 8'h00);
    send_access(REQ_READ, ADDR_SR, 32'h0, 8'h00);
    send_access(REQ_WRITE, ADDR_SR, 32'hFFFF_FFFF, 8'h00);
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = 48;
    repeat (16) send_random_access(1'b1);
    wait_drain();
    idle_on = 1'b1;
  endtask

  // bulk random traffic with idling on both sides and a few full drains
  task automatic test_random_traffic();
    int n;
    for (n = 0; n < 480; n++) begin
      send_random_access(1'b1);
      if (n % 120 == 119) wait_drain();
    end
  endtask

  // a data write while not enabled as master parks its byte until reset, so this
  // runs last: later writes overrun and no byte is ever shifted again
  task automatic test_held_transmit();
    idle_on = 1'b0;
    send_access(REQ_WRITE, ADDR_CR1, 32'h0000_0040, 8'h00);
    send_access(REQ_WRITE, ADDR_DR, 32'h0000_0011, 8'h99);
    send_access(REQ_WRITE, ADDR_DR, 32'hFFFF_FF22, 8'h66);
    send_access(REQ_WRITE, ADDR_CR1, 32'h0000_0004, 8'h00);
    send_access(REQ_WRITE, ADDR_CR1, 32'h0000_0044, 8'h00);
    send_access(REQ_WRITE, ADDR_DR, 32'h0000_0033, 8'h77);
    send_access(REQ_READ, ADDR_SR, 32'h0, 8'h00);
    send_access(REQ_WRITE, ADDR_SR, 32'h0000_000C, 8'h00);
    send_access(REQ_READ, ADDR_DR, 32'h0, 8'h00);
    repeat (90) send_random_access(1'b0);
  endtask

  initial begin
    fails        = 0;
    idle_on      = 1'b1;
    hold_request = 0;
    hold_left    = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    // register image at reset; the holding bytes are only read while valid
    cr1_q        = '0;
    cr2_q        = '0;
    csctrl_q     = '0;
    txe_q        = 1'b1;
    rxne_q       = 1'b0;
    ovr_q        = 1'b0;
    udr_q        = 1'b0;
    tx_hold_vld  = 1'b0;
    rx_hold_vld  = 1'b0;
    tx_hold_byte = '0;
    rx_hold_byte = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_READ;
    req_if.addr       = '0;
    req_if.write_data = '0;
    req_if.miso_byte  = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_bad_addresses();
    test_control_regs();
    test_transfer();
    test_backpressure();
    test_random_traffic();
    test_held_transmit();

    // let the last responses through, then watch for strays
    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0 && expected_rsp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
